@@ sv/adt_pkg.sv @@
// ----------------------------------------------------------------------------
// adt_pkg: shared constants and helpers for the IR distance display path
// Fixed-point constants, field widths, config codes and the segment encoder.
// ----------------------------------------------------------------------------
package adt_pkg;

	// field widths
	localparam int ADC_W     = 10;
	localparam int DIST_W    = 5;
	localparam int DIGIT_W   = 4;
	localparam int SEG_W     = 7;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;

	// default converter resolution
	localparam int SAMPLE_BITS_DEF = 10;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE = 1'd1;

	// config reset values
	localparam logic [CFG_W-1:0] MIN_DISTANCE_RST = 7'd10;
	localparam logic [CFG_W-1:0] MAX_DISTANCE_RST = 7'd80;

	// linearization constants
	localparam int GAIN_Q8       = 1581;       // 6.1744, 8 fraction bits
	localparam int GAIN_W        = 11;
	localparam int OFFSET_Q8     = 517606;     // 2021.9, 8 fraction bits
	localparam int ARG_FRAC      = 8;          // extra shift before the root
	localparam int COEF_Q16      = 19521;      // 0.29787 in Q0.16
	localparam int COEF_W        = 15;
	localparam int INTERCEPT_Q24 = 504893538;  // 30.094, 24 fraction bits
	localparam int FRAC_BITS     = 24;

	// common-cathode pattern gfedcba, blank for non-digits
	function automatic logic [SEG_W-1:0] seg7(input logic [DIGIT_W-1:0] digit);
		logic [SEG_W-1:0] pat;
		begin
			case (digit)
				4'd0: pat = 7'h3F;
				4'd1: pat = 7'h06;
				4'd2: pat = 7'h5B;
				4'd3: pat = 7'h4F;
				4'd4: pat = 7'h66;
				4'd5: pat = 7'h6D;
				4'd6: pat = 7'h7D;
				4'd7: pat = 7'h07;
				4'd8: pat = 7'h7F;
				4'd9: pat = 7'h6F;
				default: pat = '0;
			endcase
			return pat;
		end
	endfunction

endpackage

@@ sv/adt_if.sv @@
// ----------------------------------------------------------------------------
// adt_if: valid/ready channels of the distance display path
// Sample channel in, result channel out.
// ----------------------------------------------------------------------------
interface adt_in_if;
	logic                      valid;
	logic                      ready;
	logic [adt_pkg::ADC_W-1:0] adc_sample;

	modport source(output valid, output adc_sample, input ready);
	modport sink(input valid, input adc_sample, output ready);
endinterface

interface adt_out_if;
	logic                        valid;
	logic                        ready;
	logic                        valid_res;
	logic [adt_pkg::DIST_W-1:0]  distance_cm;
	logic [adt_pkg::DIGIT_W-1:0] tens_digit;
	logic [adt_pkg::DIGIT_W-1:0] units_digit;
	logic [adt_pkg::SEG_W-1:0]   tens_segments;
	logic [adt_pkg::SEG_W-1:0]   units_segments;

	modport source(output valid, output valid_res, output distance_cm, output tens_digit,
		output units_digit, output tens_segments, output units_segments, input ready);
	modport sink(input valid, input valid_res, input distance_cm, input tens_digit,
		input units_digit, input tens_segments, input units_segments, output ready);
endinterface

@@ sv/adt_front.sv @@
// ----------------------------------------------------------------------------
// adt_front: sample scaling stage
// Forms 1581*s - 517606 and registers it, shifted up, as the root radicand.
// ----------------------------------------------------------------------------
module adt_front #(
	parameter int SAMPLE_BITS = adt_pkg::SAMPLE_BITS_DEF,
	parameter int RADW        = 30
) (
	input  logic            clk,
	input  logic            arst_n,
	adt_in_if.sink          din,
	output logic            v_o,
	input  logic            rdy_i,
	output logic            neg_o,
	output logic [RADW-1:0] rad_o
);

	localparam int SCW = SAMPLE_BITS + adt_pkg::GAIN_W;

	logic [adt_pkg::ADC_W+SAMPLE_BITS-1:0] ext;
	logic [SAMPLE_BITS-1:0]                smp;
	logic [SCW-1:0]                        scaled;
	logic [SCW-1:0]                        arg;
	logic                                  v_s1;
	logic                                  neg_s1;
	logic [RADW-1:0]                       rad_s1;

	// low SAMPLE_BITS of the sample, zero-extended if wider than the field
	assign ext = {{SAMPLE_BITS{1'b0}}, din.adc_sample};
	assign smp = ext[SAMPLE_BITS-1:0];

	// gain and offset
	assign scaled = SCW'(adt_pkg::GAIN_Q8) * SCW'(smp);
	assign arg    = scaled - SCW'(adt_pkg::OFFSET_Q8);

	assign din.ready = !v_s1 || rdy_i;

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (din.ready) begin
			v_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (din.ready && din.valid) begin
			neg_s1 <= scaled < SCW'(adt_pkg::OFFSET_Q8);
			rad_s1 <= RADW'({arg, {adt_pkg::ARG_FRAC{1'b0}}});
		end
	end

	assign v_o   = v_s1;
	assign neg_o = neg_s1;
	assign rad_o = rad_s1;

endmodule

@@ sv/adt_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// adt_sqrt_cell: one digit of the pipelined square root
// Takes two radicand bits, decides one root bit, hands all to the next cell.
// ----------------------------------------------------------------------------
module adt_sqrt_cell #(
	parameter int RW   = 15,
	parameter int RADW = 30
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            v_i,
	output logic            rdy_o,
	input  logic            neg_i,
	input  logic [RW+1:0]   rem_i,
	input  logic [RW-1:0]   root_i,
	input  logic [RADW-1:0] rad_i,
	output logic            v_o,
	input  logic            rdy_i,
	output logic            neg_o,
	output logic [RW+1:0]   rem_o,
	output logic [RW-1:0]   root_o,
	output logic [RADW-1:0] rad_o
);

	localparam int REMW = RW + 2;

	logic [REMW+1:0] cur;
	logic [REMW+1:0] trial;
	logic            take;
	logic [REMW-1:0] rem_n;
	logic [RW-1:0]   root_n;

	logic            v_q;
	logic            neg_q;
	logic [REMW-1:0] rem_q;
	logic [RW-1:0]   root_q;
	logic [RADW-1:0] rad_q;

	// trial subtraction of (root << 2) | 1
	assign cur    = {rem_i, rad_i[RADW-1 -: 2]};
	assign trial  = (REMW+2)'({root_i, 2'b01});
	assign take   = cur >= trial;
	assign rem_n  = take ? REMW'(cur - trial) : cur[REMW-1:0];
	assign root_n = {root_i[RW-2:0], take};

	assign rdy_o = !v_q || rdy_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (rdy_o) begin
			v_q <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_o && v_i) begin
			neg_q  <= neg_i;
			rem_q  <= rem_n;
			root_q <= root_n;
			rad_q  <= {rad_i[RADW-3:0], 2'b00};
		end
	end

	assign v_o    = v_q;
	assign neg_o  = neg_q;
	assign rem_o  = rem_q;
	assign root_o = root_q;
	assign rad_o  = rad_q;

endmodule

@@ sv/adt_back.sv @@
// ----------------------------------------------------------------------------
// adt_back: distance, window test and digit encoding
// Stage 1 scales the root; stage 2 forms the distance and the output word.
// ----------------------------------------------------------------------------
module adt_back #(
	parameter int RW = 15
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       v_i,
	output logic                       rdy_o,
	input  logic                       neg_i,
	input  logic [RW-1:0]              root_i,
	input  logic [adt_pkg::CFG_W-1:0]  min_dist,
	input  logic [adt_pkg::CFG_W-1:0]  max_dist,
	adt_out_if.source                  dout
);

	localparam int PW  = RW + adt_pkg::COEF_W;
	localparam int DW  = PW + 1;
	localparam int MW  = DW - adt_pkg::FRAC_BITS;
	localparam int CW  = (MW > adt_pkg::CFG_W) ? MW : adt_pkg::CFG_W;

	logic                        v_s1;
	logic                        neg_s1;
	logic [PW-1:0]               prod_s1;
	logic                        rdy2;

	logic signed [DW-1:0]        diff;
	logic [DW-1:0]               mag;
	logic [MW-1:0]               whole;
	logic [CW-1:0]               d_c;
	logic                        ok;
	logic [adt_pkg::DIST_W-1:0]  d5;
	logic [adt_pkg::DIGIT_W-1:0] tens;
	logic [adt_pkg::DIGIT_W-1:0] units;

	logic                        v_s2;
	logic                        res_s2;
	logic [adt_pkg::DIST_W-1:0]  dist_s2;
	logic [adt_pkg::DIGIT_W-1:0] tens_s2;
	logic [adt_pkg::DIGIT_W-1:0] units_s2;
	logic [adt_pkg::SEG_W-1:0]   tseg_s2;
	logic [adt_pkg::SEG_W-1:0]   useg_s2;

	assign rdy2  = !v_s2 || dout.ready;
	assign rdy_o = !v_s1 || rdy2;

	// stage 1: root times slope
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_o) begin
			v_s1 <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_o && v_i) begin
			neg_s1  <= neg_i;
			prod_s1 <= PW'(root_i) * PW'(adt_pkg::COEF_Q16);
		end
	end

	// intercept minus product, whole part truncated toward zero
	assign diff  = $signed(DW'(adt_pkg::INTERCEPT_Q24)) - $signed({1'b0, prod_s1});
	assign mag   = diff[DW-1] ? DW'(-diff) : DW'(diff);
	assign whole = mag[DW-1 -: MW];
	assign d_c   = CW'(whole);

	// negative nonzero distance never passes; zero passes when the window allows
	assign ok = !neg_s1 && !(diff[DW-1] && (whole != '0))
		&& (d_c >= CW'(min_dist)) && (d_c <= CW'(max_dist));
	assign d5 = whole[adt_pkg::DIST_W-1:0];

	// split into digits; a passing distance stays below 32
	always_comb begin
		if (d5 >= adt_pkg::DIST_W'(30)) begin
			tens  = adt_pkg::DIGIT_W'(3);
			units = adt_pkg::DIGIT_W'(d5 - adt_pkg::DIST_W'(30));
		end else if (d5 >= adt_pkg::DIST_W'(20)) begin
			tens  = adt_pkg::DIGIT_W'(2);
			units = adt_pkg::DIGIT_W'(d5 - adt_pkg::DIST_W'(20));
		end else if (d5 >= adt_pkg::DIST_W'(10)) begin
			tens  = adt_pkg::DIGIT_W'(1);
			units = adt_pkg::DIGIT_W'(d5 - adt_pkg::DIST_W'(10));
		end else begin
			tens  = '0;
			units = adt_pkg::DIGIT_W'(d5);
		end
	end

	// stage 2: output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			res_s2   <= ok;
			dist_s2  <= ok ? d5 : '0;
			tens_s2  <= ok ? tens : '0;
			units_s2 <= ok ? units : '0;
			tseg_s2  <= ok ? adt_pkg::seg7(tens) : '0;
			useg_s2  <= ok ? adt_pkg::seg7(units) : '0;
		end
	end

	assign dout.valid          = v_s2;
	assign dout.valid_res      = res_s2;
	assign dout.distance_cm    = dist_s2;
	assign dout.tens_digit     = tens_s2;
	assign dout.units_digit    = units_s2;
	assign dout.tens_segments  = tseg_s2;
	assign dout.units_segments = useg_s2;

endmodule

@@ sv/adc_distance_to_seven_segment.sv @@
// ----------------------------------------------------------------------------
// adc_distance_to_seven_segment: IR sensor linearizer with two-digit display
// Scales a sample, takes a pipelined square root, maps it to centimeters,
// checks the window and encodes tens and units for seven-segment display.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          word
//  din      in   valid/ready        adc_sample
//  dout     out  valid/ready        valid_res, distance_cm, digits, segments
//  cfg      in   cfg_we (no wait)   cfg_idx, cfg_data
//
//  One word per cycle while dout does not stall. The stages are: one
//  scaling stage, one root cell per root bit (RW = (SAMPLE_BITS+20)/2),
//  one multiply stage and the output register.
//  Every stage has its own valid; a stalled output holds only the stages
//  behind a full one, so bubbles still fill while dout waits.
//  Reset clears stage valids and loads the window to 10..80 cm.
// ----------------------------------------------------------------------------
module adc_distance_to_seven_segment #(
	parameter int SAMPLE_BITS = adt_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	adt_in_if.sink                        din,
	adt_out_if.source                     dout,
	input  logic                          cfg_we,
	input  logic [adt_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [adt_pkg::CFG_W-1:0]     cfg_data
);

	localparam int RW   = (SAMPLE_BITS + 20) / 2;
	localparam int RADW = 2 * RW;

	logic [adt_pkg::CFG_W-1:0] min_q;
	logic [adt_pkg::CFG_W-1:0] max_q;

	// cell chain links; link 0 is the front stage output
	logic            v_w    [RW+1];
	logic            rdy_w  [RW+1];
	logic            neg_w  [RW+1];
	logic [RW+1:0]   rem_w  [RW+1];
	logic [RW-1:0]   root_w [RW+1];
	logic [RADW-1:0] rad_w  [RW+1];

	// window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= adt_pkg::MIN_DISTANCE_RST;
			max_q <= adt_pkg::MAX_DISTANCE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				adt_pkg::REG_MIN_DISTANCE: min_q <= cfg_data;
				adt_pkg::REG_MAX_DISTANCE: max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	adt_front #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.RADW       (RADW)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.din   (din),
		.v_o   (v_w[0]),
		.rdy_i (rdy_w[0]),
		.neg_o (neg_w[0]),
		.rad_o (rad_w[0])
	);

	// root and remainder start at zero
	assign rem_w[0]  = '0;
	assign root_w[0] = '0;

	// one cell per root bit
	for (genvar k = 0; k < RW; k++) begin : g_cell
		adt_sqrt_cell #(
			.RW  (RW),
			.RADW(RADW)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.v_i   (v_w[k]),
			.rdy_o (rdy_w[k]),
			.neg_i (neg_w[k]),
			.rem_i (rem_w[k]),
			.root_i(root_w[k]),
			.rad_i (rad_w[k]),
			.v_o   (v_w[k+1]),
			.rdy_i (rdy_w[k+1]),
			.neg_o (neg_w[k+1]),
			.rem_o (rem_w[k+1]),
			.root_o(root_w[k+1]),
			.rad_o (rad_w[k+1])
		);
	end

	adt_back #(
		.RW(RW)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.v_i     (v_w[RW]),
		.rdy_o   (rdy_w[RW]),
		.neg_i   (neg_w[RW]),
		.root_i  (root_w[RW]),
		.min_dist(min_q),
		.max_dist(max_q),
		.dout    (dout)
	);

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the IR distance display path
// Drives converter samples through the valid/ready input channel with random
// gaps and output stalls. Each accepted sample without a typed-in expected
// word is linearized by a local fixed-point model, and the expected display
// word is compared field by field with the word that comes out. The window
// registers are changed between phases, once the pipeline has drained.
// ----------------------------------------------------------------------------
module testbench;

	// linearization constants, 8 / 16 / 24 fraction bits
	localparam longint unsigned LIN_GAIN      = 1581;
	localparam longint unsigned LIN_OFFSET    = 517606;
	localparam int              LIN_SHIFT     = 8;
	localparam longint unsigned LIN_COEF      = 19521;
	localparam longint          LIN_INTERCEPT = 504893538;
	localparam int              LIN_FRAC      = 24;

	localparam int RANDOM_SAMPLES = 1700;
	localparam int LONG_STALL     = 400;
	// pipeline depth is 18 at 10 sample bits, keep some margin
	localparam int SETTLE_CYCLES  = 30;

	typedef struct packed {
		logic                        valid_res;
		logic [adt_pkg::DIST_W-1:0]  distance_cm;
		logic [adt_pkg::DIGIT_W-1:0] tens_digit;
		logic [adt_pkg::DIGIT_W-1:0] units_digit;
		logic [adt_pkg::SEG_W-1:0]   tens_segments;
		logic [adt_pkg::SEG_W-1:0]   units_segments;
	} display_word_t;

	typedef struct packed {
		logic [adt_pkg::ADC_W-1:0] sample;
		logic [adt_pkg::CFG_W-1:0] lo;
		logic [adt_pkg::CFG_W-1:0] hi;
		logic                      typed;
		display_word_t             word;
	} stim_row_t;

	localparam display_word_t BLANK = '0;

	// directed rows: window per row, expected word typed in only where obvious
	localparam int NUM_ROWS = 21;
	localparam stim_row_t STIM_ROWS [NUM_ROWS] = '{
		'{10'd0,    7'd10,  7'd80,  1'b1, BLANK},  // lowest sample, no root
		'{10'd327,  7'd10,  7'd80,  1'b1, BLANK},  // last negative argument
		'{10'd256,  7'd10,  7'd80,  1'b1, BLANK},
		'{10'd328,  7'd10,  7'd80,  1'b0, BLANK},  // first defined root
		'{10'd329,  7'd10,  7'd80,  1'b0, BLANK},
		'{10'd341,  7'd10,  7'd80,  1'b0, BLANK},
		'{10'd511,  7'd10,  7'd80,  1'b0, BLANK},
		'{10'd512,  7'd10,  7'd80,  1'b0, BLANK},
		'{10'd700,  7'd10,  7'd80,  1'b0, BLANK},
		'{10'd1023, 7'd10,  7'd80,  1'b0, BLANK},  // highest sample
		'{10'd0,    7'd0,   7'd127, 1'b1, BLANK},
		'{10'd328,  7'd0,   7'd127, 1'b0, BLANK},
		'{10'd600,  7'd0,   7'd127, 1'b0, BLANK},
		'{10'd1023, 7'd0,   7'd127, 1'b0, BLANK},
		'{10'd0,    7'd0,   7'd0,   1'b1, BLANK},
		'{10'd1023, 7'd0,   7'd0,   1'b0, BLANK},
		'{10'd700,  7'd50,  7'd20,  1'b1, BLANK},  // inverted window
		'{10'd1023, 7'd50,  7'd20,  1'b1, BLANK},
		'{10'd1023, 7'd127, 7'd127, 1'b1, BLANK},  // window above any distance
		'{10'd1023, 7'd10,  7'd10,  1'b0, BLANK},
		'{10'd328,  7'd30,  7'd30,  1'b0, BLANK}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic                          cfg_we;
	logic [adt_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [adt_pkg::CFG_W-1:0]     cfg_data;

	adt_in_if  din_ch ();
	adt_out_if dout_ch ();

	adc_distance_to_seven_segment uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.din      (din_ch),
		.dout     (dout_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	display_word_t             pending_words [$];
	logic [adt_pkg::CFG_W-1:0] win_lo;
	logic [adt_pkg::CFG_W-1:0] win_hi;
	int                        mismatch_count = 0;
	bit                        burst_mode = 1'b0;
	int                        stall_requests = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// common-cathode gfedcba
	function automatic logic [adt_pkg::SEG_W-1:0] digit_pattern(input int digit);
		logic [adt_pkg::SEG_W-1:0] pat;
		case (digit)
			0: pat = 7'h3F;
			1: pat = 7'h06;
			2: pat = 7'h5B;
			3: pat = 7'h4F;
			4: pat = 7'h66;
			5: pat = 7'h6D;
			6: pat = 7'h7D;
			7: pat = 7'h07;
			8: pat = 7'h7F;
			9: pat = 7'h6F;
			default: pat = '0;
		endcase
		return pat;
	endfunction

	// sample -> display word for the current window
	function automatic display_word_t linearize_sample(input logic [adt_pkg::ADC_W-1:0] sample,
		input logic [adt_pkg::CFG_W-1:0] lo, input logic [adt_pkg::CFG_W-1:0] hi);
		display_word_t   word;
		longint unsigned scaled;
		longint unsigned rad;
		longint unsigned root;
		longint unsigned bitv;
		longint          diff;
		longint          dist_cm;
		longint          lo_s;
		longint          hi_s;
		int              tens;
		int              units;
		word   = '0;
		scaled = LIN_GAIN * longint'(sample);
		lo_s   = longint'(lo);
		hi_s   = longint'(hi);
		if (scaled >= LIN_OFFSET) begin
			rad  = (scaled - LIN_OFFSET) << LIN_SHIFT;
			// bitwise integer square root
			root = 0;
			bitv = 64'h1 << 62;
			while (bitv > rad)
				bitv = bitv >> 2;
			while (bitv != 0) begin
				if (rad >= root + bitv) begin
					rad  = rad - (root + bitv);
					root = (root >> 1) + bitv;
				end else begin
					root = root >> 1;
				end
				bitv = bitv >> 2;
			end
			diff = LIN_INTERCEPT - longint'(root * LIN_COEF);
			// truncate toward zero
			if (diff >= 0)
				dist_cm = diff >>> LIN_FRAC;
			else
				dist_cm = -((-diff) >>> LIN_FRAC);
			if (dist_cm >= lo_s && dist_cm <= hi_s) begin
				tens  = int'((dist_cm / 10) % 10);
				units = int'(dist_cm % 10);
				word.valid_res      = 1'b1;
				word.distance_cm    = dist_cm[adt_pkg::DIST_W-1:0];
				word.tens_digit     = tens[adt_pkg::DIGIT_W-1:0];
				word.units_digit    = units[adt_pkg::DIGIT_W-1:0];
				word.tens_segments  = digit_pattern(tens);
				word.units_segments = digit_pattern(units);
			end
		end
		return word;
	endfunction

	task automatic check_field(input string name, input int exp_v, input int got_v);
		if (exp_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			mismatch_count++;
		end
	endtask

	// offer one word after a random gap (none in burst mode); queue its expected result on accept
	task automatic send_sample(input logic [adt_pkg::ADC_W-1:0] sample, input logic typed,
		input display_word_t typed_word);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			din_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		din_ch.valid      <= 1'b1;
		din_ch.adc_sample <= sample;
		do
			@(posedge clk);
		while (!din_ch.ready);
		if (typed)
			pending_words.push_back(typed_word);
		else
			pending_words.push_back(linearize_sample(sample, win_lo, win_hi));
	endtask

	task automatic drain_results();
		while (pending_words.size() != 0)
			@(posedge clk);
	endtask

	// both window registers, back to back; only called with the pipe empty
	task automatic write_window(input logic [adt_pkg::CFG_W-1:0] lo,
		input logic [adt_pkg::CFG_W-1:0] hi);
		cfg_we   <= 1'b1;
		cfg_idx  <= adt_pkg::REG_MIN_DISTANCE;
		cfg_data <= lo;
		@(posedge clk);
		cfg_idx  <= adt_pkg::REG_MAX_DISTANCE;
		cfg_data <= hi;
		@(posedge clk);
		cfg_we   <= 1'b0;
		win_lo = lo;
		win_hi = hi;
	endtask

	// stimulus
	initial begin
		int                        phase;
		int                        sent;
		int                        count;
		int                        pick;
		int                        waited;
		logic [adt_pkg::CFG_W-1:0] lo;
		logic [adt_pkg::CFG_W-1:0] hi;
		logic [adt_pkg::ADC_W-1:0] sample;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_idx           = adt_pkg::REG_MIN_DISTANCE;
		cfg_data          = '0;
		din_ch.valid      = 1'b0;
		din_ch.adc_sample = '0;
		win_lo            = 7'd10;
		win_hi            = 7'd80;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows, first ones against the reset window
		for (int i = 0; i < NUM_ROWS; i++) begin
			if (STIM_ROWS[i].lo != win_lo || STIM_ROWS[i].hi != win_hi) begin
				din_ch.valid <= 1'b0;
				drain_results();
				write_window(STIM_ROWS[i].lo, STIM_ROWS[i].hi);
			end
			send_sample(STIM_ROWS[i].sample, STIM_ROWS[i].typed, STIM_ROWS[i].word);
		end

		// random phases, each with its own window
		phase = 0;
		sent  = 0;
		while (sent < RANDOM_SAMPLES) begin
			din_ch.valid <= 1'b0;
			drain_results();
			case (phase)
				0: begin lo = 7'd0;   hi = 7'd127; end
				1: begin lo = 7'd127; hi = 7'd0;   end
				2: begin lo = 7'd0;   hi = 7'd35;  end
				3: begin lo = 7'd0;   hi = 7'd0;   end
				4: begin lo = 7'd127; hi = 7'd127; end
				default: begin
					pick = $urandom_range(0, 9);
					if (pick == 0) begin
						lo = adt_pkg::CFG_W'($urandom_range(20, 127));
						hi = adt_pkg::CFG_W'($urandom_range(0, int'(lo) - 1));
					end else if (pick == 1) begin
						lo = adt_pkg::CFG_W'($urandom_range(0, 127));
						hi = adt_pkg::CFG_W'($urandom_range(0, 127));
					end else begin
						lo = adt_pkg::CFG_W'($urandom_range(0, 25));
						hi = adt_pkg::CFG_W'($urandom_range(int'(lo), 40));
					end
				end
			endcase
			write_window(lo, hi);
			burst_mode = (phase == 2) || ($urandom_range(0, 4) == 0);
			// long output hold-off while the sender keeps offering
			if (phase == 2)
				stall_requests++;
			count = $urandom_range(40, 120);
			for (int k = 0; k < count; k++) begin
				// most samples in the range where the root is defined
				if ($urandom_range(0, 4) != 0)
					sample = adt_pkg::ADC_W'($urandom_range(328, 1023));
				else
					sample = adt_pkg::ADC_W'($urandom_range(0, 1023));
				send_sample(sample, 1'b0, BLANK);
			end
			sent += count;
			phase++;
		end
		din_ch.valid <= 1'b0;
		burst_mode = 1'b0;

		waited = 0;
		while (pending_words.size() != 0 && waited < 10000) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_words.size() != 0)
			$error("%0d results never arrived", pending_words.size());
		if (mismatch_count == 0 && pending_words.size() == 0) begin
			$display("PASS adc_distance_to_seven_segment");
		end else begin
			$display("FAIL adc_distance_to_seven_segment");
		end
		$finish;
	end

	// result side: random stalls, one long hold-off, field checks
	initial begin
		int            stall;
		int            stall_served;
		display_word_t want;
		stall_served  = 0;
		dout_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = burst_mode ? 0 : $urandom_range(0, 7);
			if (stall_requests != stall_served) begin
				stall = LONG_STALL;
				stall_served = stall_requests;
			end
			if (stall != 0) begin
				dout_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			dout_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!dout_ch.valid);
			if (pending_words.size() == 0) begin
				$error("result word with nothing expected");
				mismatch_count++;
			end else begin
				want = pending_words.pop_front();
				check_field("valid_res", int'(want.valid_res), int'(dout_ch.valid_res));
				check_field("distance_cm", int'(want.distance_cm),
					int'(dout_ch.distance_cm));
				check_field("tens_digit", int'(want.tens_digit), int'(dout_ch.tens_digit));
				check_field("units_digit", int'(want.units_digit),
					int'(dout_ch.units_digit));
				check_field("tens_segments", int'(want.tens_segments),
					int'(dout_ch.tens_segments));
				check_field("units_segments", int'(want.units_segments),
					int'(dout_ch.units_segments));
			end
		end
	end

	// watchdog
	initial begin
		#5000000;
		$display("FAIL adc_distance_to_seven_segment");
		$finish;
	end

endmodule
